/* sv/dqu_pkg.sv */
`default_nettype none

package dqu_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W = 3;
	localparam int STATUS_W = 2;
	localparam int DEPTH_DEF = 16;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic take_prev;
		logic take_next;
		logic load;
		logic tap;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* sv/dqu_cell.sv */
`default_nettype none

module dqu_cell (
	input  wire                   clk,
	input  dqu_pkg::cell_ctl_t    ctl,
	input  dqu_pkg::word_t        prev_data,
	input  dqu_pkg::word_t        next_data,
	input  dqu_pkg::word_t        push_word,
	output dqu_pkg::word_t        data,
	output dqu_pkg::word_t        tap_data
);
	import dqu_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.take_prev) begin
			data_q <= prev_data;
		end else if (ctl.take_next) begin
			data_q <= next_data;
		end else if (ctl.load) begin
			data_q <= push_word;
		end
	end

	assign data = data_q;
	assign tap_data = ctl.tap ? data_q : '0;

endmodule

`default_nettype wire

/* sv/double_ended_queue_unit.sv */
// A result is registered and shown in the cycle after its word is accepted.
// Throughput: one word per cycle while results are taken; cells shift or load.
// A pop from the back gathers the last occupied cell through an OR over all cells.
// Reset clears the entry count and the result valid flag; cell contents are not reset.
`default_nettype none

module double_ended_queue_unit #(
	parameter int DEPTH = dqu_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          op_valid,
	output logic                         op_ready,
	input  wire  [dqu_pkg::OP_W-1:0]     operation,
	input  wire  signed [dqu_pkg::WORD_W-1:0] push_value,
	output logic                         res_valid,
	input  wire                          res_ready,
	output logic signed [dqu_pkg::WORD_W-1:0] popped_value,
	output logic [dqu_pkg::STATUS_W-1:0] status,
	output logic [CNT_W-1:0]             entry_total,
	output logic                         is_empty
);
	import dqu_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic accept;
	logic full;
	logic empty;
	logic do_push_front;
	logic do_push_back;
	logic do_pop_front;
	logic do_pop_back;
	logic [STATUS_W-1:0] status_next;
	word_t back_word;
	word_t popped_next;
	word_t cell_data [DEPTH];
	word_t cell_tap [DEPTH];
	cell_ctl_t cell_ctl [DEPTH];

	assign op_ready = !res_valid || res_ready;
	assign accept = op_valid && op_ready;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		do_push_front = 1'b0;
		do_push_back = 1'b0;
		do_pop_front = 1'b0;
		do_pop_back = 1'b0;
		status_next = ST_OK;
		count_next = count_q;
		unique case (operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					do_push_front = (operation == OP_PUSH_FRONT);
					do_push_back = (operation == OP_PUSH_BACK);
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					do_pop_front = (operation == OP_POP_FRONT);
					do_pop_back = (operation == OP_POP_BACK);
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t prev_d;
		word_t next_d;

		if (i == 0) begin : g_first
			assign prev_d = word_t'(push_value);
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end

		assign cell_ctl[i].take_prev = accept && do_push_front;
		assign cell_ctl[i].take_next = accept && do_pop_front;
		assign cell_ctl[i].load = accept && do_push_back && (count_q == CNT_W'(i));
		assign cell_ctl[i].tap = (count_q == CNT_W'(i + 1));

		dqu_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.prev_data (prev_d),
			.next_data (next_d),
			.push_word (word_t'(push_value)),
			.data      (cell_data[i]),
			.tap_data  (cell_tap[i])
		);
	end

	always_comb begin
		back_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			back_word = back_word | cell_tap[k];
		end
	end

	always_comb begin
		priority if (do_pop_front) begin
			popped_next = cell_data[0];
		end else if (do_pop_back) begin
			popped_next = back_word;
		end else begin
			popped_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_value <= popped_next;
			status <= status_next;
			entry_total <= count_next;
			is_empty <= (count_next == '0);
		end
	end

endmodule

`default_nettype wire

/* sv/dqu_checker.sv */
`default_nettype none

module dqu_checker #(
	parameter int DEPTH = dqu_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          op_valid,
	input wire                          op_ready,
	input wire                          res_valid,
	input wire                          res_ready,
	input wire  [dqu_pkg::WORD_W-1:0]   popped_value,
	input wire  [dqu_pkg::STATUS_W-1:0] status,
	input wire  [CNT_W-1:0]             entry_total,
	input wire                          is_empty
);
	import dqu_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result word dropped before it was taken.");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> res_valid)
		else $error("Accepted word gave no result.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (is_empty == (entry_total == '0)))
		else $error("Empty flag disagrees with entry total.");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> popped_value == '0 && is_empty)
		else $error("Pop on empty queue returned data or a nonzero count.");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> entry_total == CNT_W'(DEPTH))
		else $error("Full error reported while the queue was not full.");

endmodule

bind double_ended_queue_unit dqu_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_dqu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.op_valid     (op_valid),
	.op_ready     (op_ready),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.popped_value (popped_value),
	.status       (status),
	.entry_total  (entry_total),
	.is_empty     (is_empty)
);

`default_nettype wire

/* verif/deque_result_checker.sv */
module deque_result_checker
	import dqu_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  logic                op_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [WORD_W-1:0]   push_value,
	input  logic                res_valid,
	input  logic                res_ready,
	input  logic [WORD_W-1:0]   popped_value,
	input  logic [STATUS_W-1:0] status,
	input  logic [CNT_W-1:0]    entry_total,
	input  logic                is_empty,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct packed {
		word_t                value;
		logic [STATUS_W-1:0]  status;
		logic [CNT_W-1:0]     total;
		logic                 empty;
	} deque_result_t;

	word_t ring [DEPTH];
	int front_pos;
	int held;
	deque_result_t pending_results [$];

	function automatic deque_result_t deque_apply(logic [OP_W-1:0] op, word_t word);
		deque_result_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH_FRONT: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					front_pos = (front_pos + DEPTH - 1) % DEPTH;
					ring[front_pos] = word;
					held++;
				end
			end
			OP_PUSH_BACK: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring[(front_pos + held) % DEPTH] = word;
					held++;
				end
			end
			OP_POP_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = ring[front_pos];
					front_pos = (front_pos + 1) % DEPTH;
					held--;
				end
			end
			OP_POP_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = ring[(front_pos + held - 1) % DEPTH];
					held--;
				end
			end
			OP_CLEAR: begin
				held = 0;
				front_pos = 0;
			end
			default: begin
			end
		endcase
		r.total = held[CNT_W-1:0];
		r.empty = (held == 0);
		return r;
	endfunction

	function automatic int check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			front_pos = 0;
			held = 0;
			pending_results.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word, actual value %0h status %0h total %0d",
						$time, popped_value, status, entry_total);
					errs++;
				end else begin
					want = pending_results.pop_front();
					errs += check_field("popped_value", want.value, popped_value);
					errs += check_field("status", want.status, status);
					errs += check_field("entry_total", want.total, entry_total);
					errs += check_field("is_empty", want.empty, is_empty);
				end
			end
			if (op_valid && op_ready) begin
				pending_results.push_back(deque_apply(operation, push_value));
			end
			if (errs != 0) begin
				fail_count <= fail_count + errs;
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

/* verif/tb.sv */
module tb;
	import dqu_pkg::*;

	localparam int CNT_W = $clog2(DEPTH_DEF + 1);
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_ready;
	logic [OP_W-1:0] operation;
	logic signed [WORD_W-1:0] push_value;
	logic res_valid;
	logic res_ready;
	logic signed [WORD_W-1:0] popped_value;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0] entry_total;
	logic is_empty;
	int fail_count;
	int outstanding;
	bit sender_brisk;

	double_ended_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.operation(operation),
		.push_value(push_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.popped_value(popped_value),
		.status(status),
		.entry_total(entry_total),
		.is_empty(is_empty)
	);

	deque_result_checker #(.DEPTH(DEPTH_DEF)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.operation(operation),
		.push_value(push_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.popped_value(popped_value),
		.status(status),
		.entry_total(entry_total),
		.is_empty(is_empty),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2400000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r >= 96) begin
			return (r >= 98) ? OP_CLEAR : OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		case (mode)
			MODE_FILL: begin
				if (r < 38) return OP_PUSH_FRONT;
				if (r < 76) return OP_PUSH_BACK;
				if (r < 86) return OP_POP_FRONT;
				return OP_POP_BACK;
			end
			MODE_DRAIN: begin
				if (r < 10) return OP_PUSH_FRONT;
				if (r < 20) return OP_PUSH_BACK;
				if (r < 58) return OP_POP_FRONT;
				return OP_POP_BACK;
			end
			default: begin
				if (r < 24) return OP_PUSH_FRONT;
				if (r < 48) return OP_PUSH_BACK;
				if (r < 72) return OP_POP_FRONT;
				return OP_POP_BACK;
			end
		endcase
	endfunction

	task automatic send_word(logic [OP_W-1:0] op, word_t value);
		int gap;
		gap = sender_brisk ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		operation <= op;
		push_value <= value;
		do @(posedge clk); while (!(op_valid && op_ready));
	endtask

	task automatic wait_drained();
		op_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Receiver: random stalls per word, calm stretches, and two long hold-offs
	// that let the block back up into its input.
	initial begin
		int stall;
		int words_taken;
		bit calm;
		res_ready <= 1'b0;
		words_taken = 0;
		calm = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (words_taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
			stall = calm ? 0 : $urandom_range(0, 17);
			if (words_taken == 150 || words_taken == 400) stall = 70;
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
			words_taken++;
		end
	end

	initial begin
		int mode;
		int limit;
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		operation <= OP_PUSH_FRONT;
		push_value <= '0;
		sender_brisk = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_PUSH_FRONT, 32'h8000_0000);
		send_word(OP_PUSH_BACK, 32'h7fff_ffff);
		send_word(OP_PUSH_FRONT, 32'hffff_ffff);
		send_word(OP_PUSH_BACK, 32'h0000_0000);
		for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
			send_word(OP_W'(op), pick_word());
		end
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_PUSH_BACK, 32'h5a5a_5a5a);
		send_word(OP_PUSH_FRONT, 32'ha5a5_a5a5);
		send_word(OP_CLEAR, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_CLEAR, pick_word());
		send_word(OP_PUSH_FRONT, pick_word());
		send_word(OP_POP_BACK, pick_word());
		wait_drained();

		for (int phase = 0; phase < 14; phase++) begin
			mode = (phase == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
			sender_brisk = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 38; i++) begin
				send_word(pick_op(mode), pick_word());
			end
			if (phase == 6) wait_drained();
		end
		op_valid <= 1'b0;
		@(posedge clk);

		limit = 0;
		while (outstanding != 0 && limit < 5000) begin
			@(posedge clk);
			limit++;
		end
		repeat (6) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
sv/dqu_pkg.sv
sv/dqu_cell.sv
sv/double_ended_queue_unit.sv
sv/dqu_checker.sv
verif/deque_result_checker.sv
verif/tb.sv
